// ===== hw/rtl/plti_pkg.sv =====
package plti_pkg;

  localparam int STORED_POINTS = 50;
  localparam int TABLE_POINTS  = 50;
  localparam int FRAC_BITS     = 8;
  localparam int USED_POINTS   = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                                 ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam int LAST          = USED_POINTS - 1;

  localparam int IN_W     = 24;
  localparam int OUT_W    = 19;
  localparam int ZW       = 20;   // fixed point table entries
  localparam int IDX_W    = 6;
  localparam int OFF_W    = 16;
  localparam int RUN_W    = 16;
  localparam int RISE_W   = 16;
  localparam int PROD_W   = OFF_W + RISE_W;
  localparam int RECIP_SH = 32;
  localparam int RECIP_W  = 20;
  localparam int QT_W     = PROD_W + RECIP_W;

  typedef logic [31:0]        raw_tab_t   [STORED_POINTS];
  typedef logic [ZW-1:0]      fix_tab_t   [STORED_POINTS];
  typedef logic [RUN_W-1:0]   run_tab_t   [STORED_POINTS-1];
  typedef logic [RISE_W-1:0]  rise_tab_t  [STORED_POINTS-1];
  typedef logic [RECIP_W-1:0] recip_tab_t [STORED_POINTS-1];

  // heights, 1/10000 mm
  localparam raw_tab_t HEIGHT_RAW = '{
    32'd0, 32'd663394, 32'd1325068, 32'd1968724, 32'd2626313,
    32'd3281487, 32'd3934010, 32'd4583651, 32'd5214448, 32'd5857714,
    32'd6497409, 32'd7133304, 32'd7765171, 32'd8377526, 32'd9000767,
    32'd9619305, 32'd10232918, 32'd10841382, 32'd11429833, 32'd12027477,
    32'd12619320, 32'd13205144, 32'd13784735, 32'd14343979, 32'd14910632,
    32'd15470423, 32'd16023146, 32'd16555380, 32'd17093537, 32'd17624022,
    32'd18146636, 32'd18661182, 32'd19155220, 32'd19653262, 32'd20142669,
    32'd20623254, 32'd21094835, 32'd21546062, 32'd21999325, 32'd22443055,
    32'd22877080, 32'd23301233, 32'd23705368, 32'd24109533, 32'd24503344,
    32'd24886644, 32'd25259282, 32'd25612415, 32'd25963557, 32'd26303607
  };

  // corrections, 1/10000 mm
  localparam raw_tab_t CORR_RAW = '{
    32'd0, 32'd70509, 32'd153822, 32'd247413, 32'd355926,
    32'd477136, 32'd610998, 32'd757462, 32'd912447, 32'd1083643,
    32'd1267264, 32'd1463242, 32'd1671503, 32'd1886449, 32'd2118745,
    32'd2363079, 32'd2619361, 32'd2887495, 32'd3160415, 32'd3451664,
    32'd3754454, 32'd4068671, 32'd4394198, 32'd4722569, 32'd5070079,
    32'd5428525, 32'd5797773, 32'd6168293, 32'd6558472, 32'd6959031,
    32'd7369820, 32'd7790685, 32'd8210846, 32'd8651154, 32'd9101058,
    32'd9560393, 32'd10028985, 32'd10494904, 32'd10981269, 32'd11476361,
    32'd11979995, 32'd12491983, 32'd12999352, 32'd13527279, 32'd14062982,
    32'd14606261, 32'd15156912, 32'd15701042, 32'd16265651, 32'd16837013
  };

  // round to nearest, halves up
  function automatic fix_tab_t fix_tab(raw_tab_t r);
    fix_tab_t    f;
    logic [63:0] s;
    for (int i = 0; i < STORED_POINTS; i++) begin
      s    = ({32'd0, r[i]} << FRAC_BITS) + 64'd5000;
      f[i] = ZW'(s / 64'd10000);
    end
    return f;
  endfunction

  localparam fix_tab_t HEIGHT_FIX = fix_tab(HEIGHT_RAW);
  localparam fix_tab_t CORR_FIX   = fix_tab(CORR_RAW);

  function automatic run_tab_t run_build();
    run_tab_t t;
    for (int i = 0; i < STORED_POINTS - 1; i++) begin
      if (HEIGHT_FIX[i+1] > HEIGHT_FIX[i]) t[i] = RUN_W'(HEIGHT_FIX[i+1] - HEIGHT_FIX[i]);
      else t[i] = '0;
    end
    return t;
  endfunction

  localparam run_tab_t RUN_TAB = run_build();

  // zero rise on flat or degenerate segments keeps the lower correction
  function automatic rise_tab_t rise_build();
    rise_tab_t t;
    for (int i = 0; i < STORED_POINTS - 1; i++) begin
      if (CORR_FIX[i+1] > CORR_FIX[i] && RUN_TAB[i] != '0)
        t[i] = RISE_W'(CORR_FIX[i+1] - CORR_FIX[i]);
      else t[i] = '0;
    end
    return t;
  endfunction

  localparam rise_tab_t RISE_TAB = rise_build();

  // floor(2^RECIP_SH / run) by shift and subtract; quotient estimate is low
  // by at most one
  function automatic recip_tab_t recip_build();
    recip_tab_t  t;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    num = 64'd1 << RECIP_SH;
    for (int i = 0; i < STORED_POINTS - 1; i++) begin
      rem = '0;
      q   = '0;
      for (int b = RECIP_SH; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        q   = {q[62:0], 1'b0};
        if (RUN_TAB[i] != '0 && rem >= {48'd0, RUN_TAB[i]}) begin
          rem  = rem - {48'd0, RUN_TAB[i]};
          q[0] = 1'b1;
        end
      end
      if (RUN_TAB[i] != '0) t[i] = RECIP_W'(q);
      else t[i] = '0;
    end
    return t;
  endfunction

  localparam recip_tab_t RECIP_TAB = recip_build();

  typedef struct packed {
    logic [OFF_W-1:0]   off;
    logic [RISE_W-1:0]  rise;
    logic [RUN_W-1:0]   run;
    logic [RECIP_W-1:0] recip;
    logic [OUT_W-1:0]   base;
  } seg_t;

endpackage

// ===== hw/rtl/piecewise_linear_table_interpolator_top.sv =====
// Channel  Ports                                   Direction
// -------  --------------------------------------  ---------
// in       in_valid, in_ready, in_height_pos[23:0]   input
// out      out_valid, out_ready, out_correction[18:0] output
//
// Six register stages; the result is registered in stage 6.
// One transaction per cycle sustained while the output is not stalled; the stage-4 32x20
// reciprocal multiplier sets the per-stage depth.
// rst_n is synchronous, active low, and clears only the stage valid bits.
// When out_valid is high and out_ready low, every stage holds and in_ready drops.
module piecewise_linear_table_interpolator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [plti_pkg::IN_W-1:0]   in_height_pos,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [plti_pkg::OUT_W-1:0]         out_correction
);

  logic           en;
  logic           seg_valid;
  plti_pkg::seg_t seg;

  // whole pipeline advances unless the final result is being held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stages 1-2: breakpoint compares, segment select and table fetch
  plti_seg u_seg (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .in_height_pos (in_height_pos),
    .seg_valid     (seg_valid),
    .seg_o         (seg)
  );

  // stages 3-6: product, reciprocal divide with one-step correction, add base
  plti_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .seg_valid (seg_valid),
    .seg_i     (seg),
    .res_valid (out_valid),
    .res       (out_correction)
  );

endmodule

// ===== hw/rtl/plti_seg.sv =====
module plti_seg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [plti_pkg::IN_W-1:0]    in_height_pos,
  output logic                                seg_valid,
  output plti_pkg::seg_t                      seg_o
);

  // stage 1: compare against every breakpoint
  logic                              v1_r;
  logic signed [plti_pkg::IN_W-1:0]  h1_r;
  logic [plti_pkg::LAST:0]           ge1_r;
  logic                              gt0_1_r;
  logic [plti_pkg::LAST:0]           ge_nxt;
  logic                              gt0_nxt;

  always_comb begin
    for (int i = 0; i <= plti_pkg::LAST; i++) begin
      ge_nxt[i] = in_height_pos >= $signed(plti_pkg::IN_W'(plti_pkg::HEIGHT_FIX[i]));
    end
    gt0_nxt = in_height_pos > $signed(plti_pkg::IN_W'(plti_pkg::HEIGHT_FIX[0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r    <= in_height_pos;
      ge1_r   <= ge_nxt;
      gt0_1_r <= gt0_nxt;
    end
  end

  // stage 2: pick segment, fetch its constants
  logic [plti_pkg::IDX_W-1:0] idx;
  logic [plti_pkg::IN_W-1:0]  diff;
  plti_pkg::seg_t             seg_nxt;
  plti_pkg::seg_t             seg_r;
  logic                       v2_r;

  always_comb begin
    idx = '0;
    for (int i = 1; i < plti_pkg::LAST; i++) begin
      if (ge1_r[i]) idx = plti_pkg::IDX_W'(i);
    end
    diff          = h1_r - plti_pkg::IN_W'(plti_pkg::HEIGHT_FIX[idx]);
    seg_nxt.off   = diff[plti_pkg::OFF_W-1:0];
    seg_nxt.rise  = plti_pkg::RISE_TAB[idx];
    seg_nxt.run   = plti_pkg::RUN_TAB[idx];
    seg_nxt.recip = plti_pkg::RECIP_TAB[idx];
    seg_nxt.base  = plti_pkg::OUT_W'(plti_pkg::CORR_FIX[idx]);
    if (!gt0_1_r || ge1_r[plti_pkg::LAST]) begin
      seg_nxt.off  = '0;
      seg_nxt.rise = '0;
      seg_nxt.run  = '0;
      seg_nxt.base = gt0_1_r ? plti_pkg::OUT_W'(plti_pkg::CORR_FIX[plti_pkg::LAST])
                             : plti_pkg::OUT_W'(plti_pkg::CORR_FIX[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r <= seg_nxt;
    end
  end

  assign seg_valid = v2_r;
  assign seg_o     = seg_r;

endmodule

// ===== hw/rtl/plti_div.sv =====
module plti_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        seg_valid,
  input  plti_pkg::seg_t              seg_i,
  output logic                        res_valid,
  output logic [plti_pkg::OUT_W-1:0]  res
);

  // stage 3: off * rise
  logic                          v3_r;
  logic [plti_pkg::PROD_W-1:0]   p3_r;
  logic [plti_pkg::RUN_W-1:0]    run3_r;
  logic [plti_pkg::RECIP_W-1:0]  recip3_r;
  logic [plti_pkg::OUT_W-1:0]    base3_r;

  // stage 4: quotient estimate
  logic                          v4_r;
  logic [plti_pkg::PROD_W-1:0]   p4_r;
  logic [plti_pkg::RUN_W-1:0]    run4_r;
  logic [plti_pkg::RISE_W-1:0]   q4_r;
  logic [plti_pkg::OUT_W-1:0]    base4_r;
  logic [plti_pkg::QT_W-1:0]     qt;

  // stage 5: back-multiply
  logic                          v5_r;
  logic [plti_pkg::PROD_W-1:0]   p5_r;
  logic [plti_pkg::PROD_W-1:0]   qr5_r;
  logic [plti_pkg::RUN_W-1:0]    run5_r;
  logic [plti_pkg::RISE_W-1:0]   q5_r;
  logic [plti_pkg::OUT_W-1:0]    base5_r;

  // stage 6: correct and add
  logic                          v6_r;
  logic [plti_pkg::OUT_W-1:0]    res6_r;
  logic [plti_pkg::PROD_W-1:0]   rem;
  logic                          inc;
  logic [plti_pkg::OUT_W-1:0]    res_nxt;

  assign qt      = plti_pkg::QT_W'(p3_r) * plti_pkg::QT_W'(recip3_r);
  assign rem     = p5_r - qr5_r;
  assign inc     = (run5_r != '0) && (rem >= plti_pkg::PROD_W'(run5_r));
  assign res_nxt = base5_r + plti_pkg::OUT_W'(q5_r) + plti_pkg::OUT_W'(inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v3_r <= seg_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r     <= plti_pkg::PROD_W'(seg_i.off) * plti_pkg::PROD_W'(seg_i.rise);
      run3_r   <= seg_i.run;
      recip3_r <= seg_i.recip;
      base3_r  <= seg_i.base;

      p4_r     <= p3_r;
      run4_r   <= run3_r;
      base4_r  <= base3_r;
      q4_r     <= plti_pkg::RISE_W'(qt >> plti_pkg::RECIP_SH);

      p5_r     <= p4_r;
      qr5_r    <= plti_pkg::PROD_W'(q4_r) * plti_pkg::PROD_W'(run4_r);
      run5_r   <= run4_r;
      q5_r     <= q4_r;
      base5_r  <= base4_r;

      res6_r   <= res_nxt;
    end
  end

  assign res_valid = v6_r;
  assign res       = res6_r;

  // estimate is never high and at most one low
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && run5_r != '0 |-> p5_r >= qr5_r && rem < (plti_pkg::PROD_W'(run5_r) << 1))
    else $error("quotient estimate off by more than one");

  a_res_max: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> res6_r <= plti_pkg::OUT_W'(plti_pkg::CORR_FIX[plti_pkg::LAST]))
    else $error("correction above last table value");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({v3_r, v4_r, v5_r, v6_r}) && $stable(res6_r))
    else $error("pipeline moved during stall");

endmodule
